// ===== rtl/distance_vector_route_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit_defines
// assertion macros shared by the route table checker
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH

// property checked only while out of reset
`define DVRT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dvrt check failed");

// property checked at every edge, reset included
`define DVRT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dvrt reset check failed");

`endif

// ===== rtl/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// types and constants of the distance vector route table
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 8;
    localparam logic [15:0] COST_INF = 16'hFFFF;

    // command codes
    typedef enum logic [2:0] {
        CMD_LOAD     = 3'd0,
        CMD_SET_LINK = 3'd1,
        CMD_RELAX    = 3'd2,
        CMD_READ     = 3'd3,
        CMD_NBR_DOWN = 3'd4
    } t_cmd;

    // request class seen by the controller
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_READ,
        KIND_SEARCH,
        KIND_FAIL
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_SCAN,
        ST_CHECK,
        ST_UPDATE,
        ST_DONE
    } t_state;

    // one stored table entry
    typedef struct packed {
        logic [15:0] router;
        logic [15:0] cost;
        logic [15:0] link_cost;
        logic [15:0] hop_id;
        logic        is_nbr;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one response
    typedef struct packed {
        logic [15:0] entry_id;
        logic [15:0] hop_id;
        logic [15:0] cost;
        logic        nbr;
        logic        changed;
        logic        status;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic rd_slot;
        logic read_res;
        logic fail;
        logic sweep_start;
        logic sweep_upd;
        logic sweep_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  sweep_done;
        logic  first_found;
    } t_dp_stat;

endpackage

// ===== rtl/dvrt_ram.sv =====
// ----------------------------------------------------------------------------
// dvrt_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dvrt_ram #(
    parameter int WIDTH = dvrt_pkg::ENTRY_W,
    parameter int DEPTH = dvrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dvrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvrt_ctrl
// request sequencer: decode, table sweeps and response handoff
// ----------------------------------------------------------------------------
module dvrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  dvrt_pkg::t_dp_stat i_stat,
    output dvrt_pkg::t_dp_cmd  o_ctl
);
    import dvrt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    // state register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (i_stat.kind)
                    KIND_LOAD:   n_state = ST_DONE;
                    KIND_READ:   n_state = ST_READ_WAIT;
                    KIND_SEARCH: n_state = ST_SCAN;
                    KIND_FAIL:   n_state = ST_DONE;
                endcase
            end
            ST_READ_WAIT: n_state = ST_DONE;
            ST_SCAN: begin
                if (i_stat.sweep_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.first_found ? ST_UPDATE : ST_DONE;
            end
            ST_UPDATE: begin
                if (i_stat.sweep_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready     = 1'b1;
                o_ctl.capture = i_valid;
            end
            ST_DECODE: begin
                unique case (i_stat.kind)
                    KIND_LOAD:   o_ctl.load = 1'b1;
                    KIND_READ:   o_ctl.rd_slot = 1'b1;
                    KIND_SEARCH: o_ctl.sweep_start = 1'b1;
                    KIND_FAIL:   o_ctl.fail = 1'b1;
                endcase
            end
            ST_READ_WAIT: o_ctl.read_res = 1'b1;
            ST_SCAN:      o_ctl.sweep_step = 1'b1;
            ST_CHECK: begin
                if (i_stat.first_found) begin
                    o_ctl.sweep_start = 1'b1;
                    o_ctl.sweep_upd   = 1'b1;
                end else begin
                    o_ctl.fail = 1'b1;
                end
            end
            ST_UPDATE:    o_ctl.sweep_step = 1'b1;
            ST_DONE:      o_ctl.out_load = out_free;
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/dvrt_dp.sv =====
// ----------------------------------------------------------------------------
// dvrt_dp
// route table datapath: entry ram, valid bits, sweep counter, relax math
// ----------------------------------------------------------------------------
module dvrt_dp #(
    parameter int TABLE_DEPTH = dvrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dvrt_pkg::t_dp_cmd  i_ctl,
    output dvrt_pkg::t_dp_stat o_stat,
    input  logic [2:0]         i_cmd,
    input  logic [2:0]         i_slot,
    input  logic [15:0]        i_node_id,
    input  logic [15:0]        i_peer_id,
    input  logic [15:0]        i_cost_in,
    input  logic               i_clear_first,
    output logic [15:0]        o_entry_id,
    output logic [15:0]        o_hop_id,
    output logic [15:0]        o_cost_out,
    output logic               o_neighbour,
    output logic               o_changed,
    output logic               o_status
);
    import dvrt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_DEPTH);

    // captured request
    t_cmd        r_cmd;
    logic [2:0]  r_slot;
    logic [15:0] r_rid;
    logic [15:0] r_peer;
    logic [15:0] r_cost;
    logic        r_clear;

    // table state
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] n_valid;
    logic [15:0]            r_own;

    // sweep state
    logic [CW-1:0] r_cnt;
    logic          r_pend;
    logic [IW-1:0] r_pend_idx;
    logic          r_upd;
    logic          r_first_found;
    logic [IW-1:0] r_first_idx;
    logic          r_peer_found;
    logic [15:0]   r_peer_link;
    logic [15:0]   r_sum;
    logic          r_relax_ok;

    t_result r_res;
    t_result r_out;

    // ram ports
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic          slot_ok;
    logic [IW-1:0] slot_idx;
    t_entry        load_entry;
    t_entry        rd_entry;
    t_entry        upd_entry;
    logic          upd_ch;
    logic          match_rid;
    logic          match_peer;
    logic [16:0]   sum_full;
    logic [15:0]   sum_sat;
    t_kind         kind;

    assign slot_ok  = ({29'd0, r_slot} < 32'(TABLE_DEPTH));
    assign slot_idx = IW'(r_slot);
    assign rd_entry = t_entry'(ram_rdata);

    // entry written by a load
    always_comb begin
        load_entry.router    = r_rid;
        load_entry.cost      = r_cost;
        load_entry.link_cost = r_cost;
        if (r_cost == 16'd0) begin
            load_entry.hop_id = r_rid;
            load_entry.is_nbr = 1'b0;
        end else if (r_cost == COST_INF) begin
            load_entry.hop_id = COST_INF;
            load_entry.is_nbr = 1'b0;
        end else begin
            load_entry.hop_id = r_rid;
            load_entry.is_nbr = 1'b1;
        end
    end

    // valid bits after a load
    always_comb begin
        n_valid = r_valid;
        if (r_clear) n_valid = '0;
        n_valid[slot_idx] = 1'b1;
    end

    // request decoder
    always_comb begin
        unique case (r_cmd) inside
            CMD_LOAD: kind = slot_ok ? KIND_LOAD : KIND_FAIL;
            CMD_READ: kind = (slot_ok && r_valid[slot_idx]) ? KIND_READ : KIND_FAIL;
            CMD_SET_LINK, CMD_RELAX, CMD_NBR_DOWN: kind = KIND_SEARCH;
            default: kind = KIND_FAIL;
        endcase
    end

    // id compare on the entry coming out of the ram
    assign match_rid  = r_pend && r_valid[r_pend_idx] && (rd_entry.router == r_rid);
    assign match_peer = r_pend && r_valid[r_pend_idx] && (rd_entry.router == r_peer);

    // saturating path cost through the peer
    assign sum_full = {1'b0, r_peer_link} + {1'b0, r_cost};
    assign sum_sat  = sum_full[16] ? COST_INF : sum_full[15:0];

    // per entry update
    always_comb begin
        upd_entry = rd_entry;
        upd_ch    = 1'b0;
        case (r_cmd)
            CMD_SET_LINK: begin
                upd_ch = (rd_entry.cost != r_cost) || (rd_entry.link_cost != r_cost);
                upd_entry.cost      = r_cost;
                upd_entry.link_cost = r_cost;
            end
            CMD_NBR_DOWN: begin
                upd_ch = (rd_entry.cost != COST_INF) || rd_entry.is_nbr;
                upd_entry.cost   = COST_INF;
                upd_entry.is_nbr = 1'b0;
            end
            CMD_RELAX: begin
                if (r_relax_ok && (rd_entry.cost > r_cost) && (r_sum < rd_entry.cost)) begin
                    upd_ch = 1'b1;
                    upd_entry.cost   = r_sum;
                    upd_entry.hop_id = r_peer;
                end
            end
            default: ;
        endcase
    end

    // ram address and write selection
    assign ram_we    = i_ctl.load || (i_ctl.sweep_step && r_upd && match_rid);
    assign ram_waddr = i_ctl.load ? slot_idx : r_pend_idx;
    assign ram_wdata = i_ctl.load ? ENTRY_W'(load_entry) : ENTRY_W'(upd_entry);
    assign ram_raddr = i_ctl.rd_slot ? slot_idx : r_cnt[IW-1:0];

    dvrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state: valid bits, own id, sweep counter and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_own         <= '0;
            r_cnt         <= '0;
            r_pend        <= 1'b0;
            r_pend_idx    <= '0;
            r_upd         <= 1'b0;
            r_first_found <= 1'b0;
            r_peer_found  <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_valid <= n_valid;
                if (r_cost == 16'd0) r_own <= r_rid;
            end
            if (i_ctl.sweep_start) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
                r_upd  <= i_ctl.sweep_upd;
                if (!i_ctl.sweep_upd) begin
                    r_first_found <= 1'b0;
                    r_peer_found  <= 1'b0;
                end
            end else if (i_ctl.sweep_step) begin
                if (r_cnt < CNT_END) begin
                    r_cnt      <= r_cnt + 1'b1;
                    r_pend     <= 1'b1;
                    r_pend_idx <= r_cnt[IW-1:0];
                end else begin
                    r_pend <= 1'b0;
                end
                if (!r_upd && match_rid) r_first_found <= 1'b1;
                if (!r_upd && match_peer) r_peer_found <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_slot  <= i_slot;
            r_rid   <= i_node_id;
            r_peer  <= i_peer_id;
            r_cost  <= i_cost_in;
            r_clear <= i_clear_first;
        end
        // lowest matching slots during the search sweep
        if (i_ctl.sweep_step && !r_upd) begin
            if (match_rid && !r_first_found) r_first_idx <= r_pend_idx;
            if (match_peer && !r_peer_found) r_peer_link <= rd_entry.link_cost;
        end
        if (i_ctl.sweep_start && i_ctl.sweep_upd) begin
            r_sum      <= sum_sat;
            r_relax_ok <= (r_rid != r_peer) && (r_rid != r_own) && r_peer_found;
        end
        // response assembly
        if (i_ctl.load) begin
            r_res <= '{entry_id: load_entry.router, hop_id: load_entry.hop_id,
                       cost: load_entry.cost, nbr: load_entry.is_nbr,
                       changed: 1'b1, status: 1'b0};
        end else if (i_ctl.read_res) begin
            r_res <= '{entry_id: rd_entry.router, hop_id: rd_entry.hop_id,
                       cost: rd_entry.cost, nbr: rd_entry.is_nbr,
                       changed: 1'b0, status: 1'b0};
        end else if (i_ctl.fail) begin
            r_res <= '{entry_id: 16'd0, hop_id: 16'd0, cost: 16'd0, nbr: 1'b0,
                       changed: 1'b0, status: 1'b1};
        end else if (i_ctl.sweep_step && r_upd && r_pend && (r_pend_idx == r_first_idx)) begin
            r_res <= '{entry_id: upd_entry.router, hop_id: upd_entry.hop_id,
                       cost: upd_entry.cost, nbr: upd_entry.is_nbr,
                       changed: upd_ch, status: 1'b0};
        end
        if (i_ctl.out_load) r_out <= r_res;
    end

    assign o_stat.kind        = kind;
    assign o_stat.sweep_done  = r_pend && (r_pend_idx == LAST_IDX);
    assign o_stat.first_found = r_first_found;

    assign o_entry_id  = r_out.entry_id;
    assign o_hop_id    = r_out.hop_id;
    assign o_cost_out  = r_out.cost;
    assign o_neighbour = r_out.nbr;
    assign o_changed   = r_out.changed;
    assign o_status    = r_out.status;

endmodule

// ===== rtl/distance_vector_route_table_unit.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit
// distance vector routing table with load, link cost, relax, read and
// neighbour down requests
// ----------------------------------------------------------------------------
// Requests enter on i_valid/o_ready and every request gives one response on
// o_valid/i_ready. One request is in work at a time; o_ready is high only
// while the sequencer is idle, also while an earlier response still waits.
// After acceptance the sequencer decodes the request; a load or a request
// that fails at decode then goes to the done state, a slot read waits for
// the registered ram read, and set link cost, relax and neighbour down
// sweep the table. The response is loaded into the output register from the
// done state, and the sequencer then returns to idle. Searches walk the
// entry ram one entry per cycle over its single read port: a search pass
// finds the lowest matching slot and the peer link cost, and when a valid
// entry matches, an update pass rewrites every matching entry. Entry fields
// live in ram; valid bits and the own router id are flops cleared by reset,
// so the table is empty right after reset with no clearing pass. A stalled
// receiver holds the response in the output register; the next request may
// be accepted meanwhile, and its response waits in the result register while
// the sequencer holds in its done state until the output register frees up.
// ----------------------------------------------------------------------------
module distance_vector_route_table_unit #(
    parameter int TABLE_DEPTH = dvrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_slot,
    input  logic [15:0] i_node_id,
    input  logic [15:0] i_peer_id,
    input  logic [15:0] i_cost_in,
    input  logic        i_clear_first,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_entry_id,
    output logic [15:0] o_hop_id,
    output logic [15:0] o_cost_out,
    output logic        o_neighbour,
    output logic        o_changed,
    output logic        o_status
);
    import dvrt_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // sequencer
    dvrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    // table datapath
    dvrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .i_cmd         (i_cmd),
        .i_slot        (i_slot),
        .i_node_id     (i_node_id),
        .i_peer_id     (i_peer_id),
        .i_cost_in     (i_cost_in),
        .i_clear_first (i_clear_first),
        .o_entry_id    (o_entry_id),
        .o_hop_id      (o_hop_id),
        .o_cost_out    (o_cost_out),
        .o_neighbour   (o_neighbour),
        .o_changed     (o_changed),
        .o_status      (o_status)
    );

endmodule

// ===== rtl/dvrt_checker.sv =====
// ----------------------------------------------------------------------------
// dvrt_checker
// port level checks of the route table, bound to the top level
// ----------------------------------------------------------------------------
`include "distance_vector_route_table_unit_defines.svh"

module dvrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_entry_id,
    input logic [15:0] o_hop_id,
    input logic [15:0] o_cost_out,
    input logic        o_neighbour,
    input logic        o_changed,
    input logic        o_status
);

    // a stalled response holds
    `DVRT_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_entry_id) && $stable(o_hop_id) && $stable(o_cost_out) && $stable(o_status) && $stable(o_changed)))

    // a failed request reports all fields zero
    `DVRT_ASSERT(a_fail_zero, (o_valid && o_status) |-> (o_entry_id == 16'd0 && o_hop_id == 16'd0 && o_cost_out == 16'd0 && !o_neighbour && !o_changed))

    // one request in work at a time
    `DVRT_ASSERT(a_one_in_work, (i_valid && o_ready) |=> !o_ready)

    // no response right out of reset
    `DVRT_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid)

endmodule

bind distance_vector_route_table_unit dvrt_checker u_dvrt_checker (.*);
